/* src/waveform_peak_summary_assert.svh */
// Assertion macros for the waveform peak summary block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef WAVEFORM_PEAK_SUMMARY_ASSERT_SVH
`define WAVEFORM_PEAK_SUMMARY_ASSERT_SVH

`ifndef SYNTHESIS

`define WPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WPS_ASSERT_IMPL(lbl, ante, cons, msg)

`define WPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/wps_pkg.sv */
// Shared types and constants for the waveform peak summary block.
// No dependencies.
`default_nettype none

package wps_pkg;

  localparam int SampleW     = 24;
  localparam int MaxChannels = 8;
  localparam int MaxBuckets  = 1024;
  localparam int ChCfgW      = 4;
  localparam int BktCfgW     = 11;
  localparam int FrameW      = 40;
  localparam int PosW        = $clog2(MaxChannels);
  localparam int SumW        = SampleW + PosW;
  localparam int AddrW       = $clog2(MaxBuckets);
  localparam int ProdW       = FrameW + BktCfgW;
  localparam int DivCntW     = $clog2(ProdW + 1);
  localparam int CfgAddrW    = 2;

  localparam logic [FrameW-1:0] FrameMax = {FrameW{1'b1}};

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_BUCKET_COUNT  = 2'd1,
    CFG_TRACK_FRAMES  = 2'd2
  } cfg_addr_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FETCH,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // full average width: a frame closed early by a smaller channel count can exceed Q1.23
  typedef struct packed {
    logic signed [SumW-1:0] min_val;
    logic signed [SumW-1:0] max_val;
  } store_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
    store_entry_t     wr_data;
  } store_req_t;

  typedef struct packed {
    logic              start;
    logic              short_run;
    logic [ProdW-1:0]  dividend;
    logic [FrameW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/wps_if.sv */
// Handshake channel interfaces: sample/command requests, bucket results, config writes.
// Depends on wps_pkg.
`default_nettype none

interface wps_in_if import wps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic signed [SampleW-1:0] sample;
  logic [AddrW-1:0]          bucket_index;

  modport source (output valid, command, sample, bucket_index, input ready);
  modport sink (input valid, command, sample, bucket_index, output ready);
endinterface

interface wps_out_if import wps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] bucket_min;
  logic signed [SampleW-1:0] bucket_max;
  logic [FrameW-1:0]         frames_seen;

  modport source (output valid, bucket_min, bucket_max, frames_seen, input ready);
  modport sink (input valid, bucket_min, bucket_max, frames_seen, output ready);
endinterface

interface wps_cfg_if import wps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [FrameW-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* src/wps_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on wps_pkg. Short runs cover the frame average, full runs the bucket position.
`default_nettype none

module wps_div import wps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0]   quo_q, quo_d;
  logic [FrameW-1:0]  rem_q, rem_d;
  logic [FrameW-1:0]  dvs_q, dvs_d;

  logic [FrameW:0]    shifted;
  logic [FrameW+1:0]  trial;

  always_comb begin
    shifted = {rem_q, quo_q[ProdW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.short_run ? DivCntW'(SumW) : DivCntW'(ProdW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[FrameW+1]) begin
        rem_d = trial[FrameW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[FrameW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* src/wps_store.sv */
// Min/max bucket store, one port, registered read.
// Depends on wps_pkg.
`default_nettype none

module wps_store import wps_pkg::*; (
  input  wire logic       clk_i,
  input  wire store_req_t req_i,
  output store_entry_t    rd_data_o
);

  store_entry_t mem [MaxBuckets];
  store_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* src/waveform_peak_summary.sv */
// Waveform peak summary top level: sequencer, counters, config registers.
// Depends on wps_pkg, wps_if, wps_div, wps_store and waveform_peak_summary_assert.svh.
//
// Takes one request at a time; ready is high only while the sequencer is idle.
// A push that does not finish a frame adds its sample to the sum; the block stays
// idle. A push that finishes a frame runs the average on the one bit-per-cycle
// divider, a multiply, the bucket position on the same divider, a store read and
// a store write. With a used bucket count of zero the bucket steps are skipped.
// A read waits in the response state while an earlier result is still held; its
// result sits in an output register, so further requests are taken as it waits.
// A clear, and reset itself, sweep the 1024-entry store one entry a cycle, and the
// block stays busy until the sweep is done. Config writes are taken in any cycle.
`default_nettype none

module waveform_peak_summary import wps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wps_in_if.sink    in_req,
  wps_out_if.source out_rsp,
  wps_cfg_if.sink   cfg
);

  `include "waveform_peak_summary_assert.svh"

  state_e state_q, state_d;

  logic [ChCfgW-1:0]  chan_cfg_q;
  logic [BktCfgW-1:0] bkt_cfg_q;
  logic [FrameW-1:0]  track_q;

  logic [FrameW-1:0]         frame_q, frame_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [SumW-1:0]    avg_q, avg_d;
  logic [ProdW-1:0]          prod_q, prod_d;
  logic [AddrW-1:0]          bkt_q, bkt_d;
  logic [AddrW-1:0]          clr_q, clr_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_min_q, out_max_q;
  logic [FrameW-1:0]         out_frames_q;
  logic                      out_load;

  logic       in_fire;
  cmd_e       cmd;
  logic       frame_done;
  logic       clear_done;
  logic       div_done;

  logic [ChCfgW-1:0]  ch_eff;
  logic [BktCfgW-1:0] req_bkts;
  logic [BktCfgW-1:0] used;
  logic [BktCfgW-1:0] last_bkt;
  logic [ProdW-1:0]   clamped;
  logic [SumW-1:0]    abs_sum;
  logic [SumW-1:0]    mag;
  logic [SumW-1:0]    signed_avg;
  logic signed [SumW-1:0] sample_ext;
  logic [FrameW-1:0]  frame_inc;

  store_req_t   st_req;
  store_entry_t st_rd;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  wps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wps_store u_store (
    .clk_i     (clk_i),
    .req_i     (st_req),
    .rd_data_o (st_rd)
  );

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q <= ChCfgW'(1);
      bkt_cfg_q  <= BktCfgW'(MaxBuckets);
      track_q    <= '0;
    end else if (cfg.valid) begin
      case (cfg_addr_e'(cfg.addr))
        CFG_CHANNEL_COUNT: chan_cfg_q <= cfg.data[ChCfgW-1:0];
        CFG_BUCKET_COUNT:  bkt_cfg_q  <= cfg.data[BktCfgW-1:0];
        CFG_TRACK_FRAMES:  track_q    <= cfg.data;
        default:           ;
      endcase
    end
  end

  // derived values
  always_comb begin
    if (chan_cfg_q == '0) begin
      ch_eff = ChCfgW'(1);
    end else if (chan_cfg_q > ChCfgW'(MaxChannels)) begin
      ch_eff = ChCfgW'(MaxChannels);
    end else begin
      ch_eff = chan_cfg_q;
    end
    req_bkts = (bkt_cfg_q > BktCfgW'(MaxBuckets)) ? BktCfgW'(MaxBuckets) : bkt_cfg_q;
    used     = ({{(FrameW-BktCfgW){1'b0}}, req_bkts} < track_q) ? req_bkts
                                                                : track_q[BktCfgW-1:0];
    last_bkt = used - BktCfgW'(1);
    clamped  = (div_rsp.quotient > {{(ProdW-BktCfgW){1'b0}}, last_bkt})
               ? {{(ProdW-BktCfgW){1'b0}}, last_bkt} : div_rsp.quotient;
    abs_sum  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    mag      = div_rsp.quotient[SumW-1:0];
    signed_avg = sum_q[SumW-1] ? (-mag) : mag;
    sample_ext = {{(SumW-SampleW){in_req.sample[SampleW-1]}}, in_req.sample};
    frame_inc  = (frame_q != FrameMax) ? (frame_q + FrameW'(1)) : frame_q;
  end

  assign in_fire    = in_req.valid & in_req.ready;
  assign cmd        = cmd_e'(in_req.command);
  assign frame_done = ({1'b0, pos_q} + ChCfgW'(1)) >= ch_eff;
  assign clear_done = clr_q == AddrW'(MaxBuckets - 1);
  assign div_done   = div_rsp.done;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_PUSH:  if (frame_done) state_d = ST_AVG_GO;
            CMD_READ:  state_d = ST_RESP;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   ;
          endcase
        end
      end
      ST_AVG_GO:   state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_done) state_d = (used == '0) ? ST_IDLE : ST_MUL;
      ST_MUL:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_FETCH;
      ST_FETCH:    state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_IDLE;
      ST_RESP:     if (!out_valid_q || out_rsp.ready) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_req.ready      = state_q == ST_IDLE;
    out_load          = 1'b0;
    st_req            = '0;
    div_req           = '0;
    div_req.divisor   = track_q;
    div_req.dividend  = prod_q;
    case (state_q)
      ST_CLEAR: begin
        st_req.wr_en = 1'b1;
        st_req.addr  = clr_q;
      end
      ST_IDLE: begin
        st_req.rd_en = in_fire && (cmd == CMD_READ);
        st_req.addr  = in_req.bucket_index;
      end
      ST_AVG_GO: begin
        div_req.start     = 1'b1;
        div_req.short_run = 1'b1;
        div_req.dividend  = {abs_sum, {(ProdW-SumW){1'b0}}};
        div_req.divisor   = {{(FrameW-ChCfgW){1'b0}}, ch_eff};
      end
      ST_DIV_GO: div_req.start = 1'b1;
      ST_FETCH: begin
        st_req.rd_en = 1'b1;
        st_req.addr  = bkt_q;
      end
      ST_UPDATE: begin
        st_req.wr_en = 1'b1;
        st_req.addr  = bkt_q;
        st_req.wr_data.min_val = (avg_q < st_rd.min_val) ? avg_q : st_rd.min_val;
        st_req.wr_data.max_val = (avg_q > st_rd.max_val) ? avg_q : st_rd.max_val;
      end
      ST_RESP: out_load = !out_valid_q || out_rsp.ready;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    frame_d = frame_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    avg_d   = avg_q;
    prod_d  = prod_q;
    bkt_d   = bkt_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + AddrW'(1);
      ST_IDLE: begin
        clr_d = '0;
        if (in_fire) begin
          case (cmd)
            CMD_PUSH: begin
              sum_d = sum_q + sample_ext;
              pos_d = frame_done ? '0 : pos_q + PosW'(1);
            end
            CMD_CLEAR: begin
              frame_d = '0;
              pos_d   = '0;
              sum_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_AVG_WAIT: begin
        if (div_done) begin
          avg_d = $signed(signed_avg);
          sum_d = '0;
          if (used == '0) frame_d = frame_inc;
        end
      end
      ST_MUL: prod_d = frame_q * {{(FrameW-BktCfgW){1'b0}}, used};
      ST_DIV_WAIT: if (div_done) bkt_d = clamped[AddrW-1:0];
      ST_UPDATE: frame_d = frame_inc;
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      frame_q     <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q  <= avg_d;
    prod_q <= prod_d;
    bkt_q  <= bkt_d;
    if (out_load) begin
      out_min_q    <= st_rd.min_val[SampleW-1:0];
      out_max_q    <= st_rd.max_val[SampleW-1:0];
      out_frames_q <= frame_q;
    end
  end

  assign out_rsp.valid       = out_valid_q;
  assign out_rsp.bucket_min  = out_min_q;
  assign out_rsp.bucket_max  = out_max_q;
  assign out_rsp.frames_seen = out_frames_q;

  `WPS_ASSERT_IMPL(a_div_done_expected, div_rsp.done,
    (state_q == ST_AVG_WAIT) || (state_q == ST_DIV_WAIT), "divider done out of sequence")

  `WPS_ASSERT_IMPL(a_update_in_range, state_q == ST_UPDATE,
    {1'b0, bkt_q} < used, "bucket write beyond used count")

  `WPS_ASSERT_NEXT(a_frame_monotonic, !(in_fire && (cmd == CMD_CLEAR)),
    frame_q >= $past(frame_q), "frame counter went backward without clear")

endmodule

`default_nettype wire
